>>> rtl/core/ordered_list_engine_unit_macros.svh
// Assertion macros shared by the ordered list engine RTL.
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define OLE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define OLE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ole_pkg.sv
// Types and constants of the ordered list engine.
package ole_pkg;

    localparam int DEPTH    = 16;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int DATA_W   = 32;
    localparam int ACT_W    = 3;
    localparam int POS_W    = 4;
    localparam int STAT_W   = 3;
    localparam int COUNT_W  = 5;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic [ACT_W-1:0] {
        ACT_APPEND = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_DELETE = 3'd2,
        ACT_CLEAR  = 3'd3,
        ACT_READ   = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_EMPTY     = 3'd1,
        STAT_NOT_FOUND = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_RANGE     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_APPLY
    } t_state;

    // Per-cell command from the sequencer.
    typedef struct packed {
        logic live;       // cell holds a valid entry
        logic eval;       // capture compare flags
        logic take_val;   // load the operand
        logic take_prev;  // shift toward the tail
        logic take_next;  // shift toward the head
    } t_cell_ctl;

    // Registered compare flags of one cell.
    typedef struct packed {
        logic stop_ins;   // insert slot is here or earlier
        logic hit_del;    // entry equals the operand
    } t_cell_flags;

endpackage

>>> rtl/core/ole_if.sv
// Input and output word channels of the ordered list engine.
interface ole_in_if;
    logic                        valid;
    logic                        ready;
    logic [ole_pkg::ACT_W-1:0]   action;
    ole_pkg::t_data              value;
    logic [ole_pkg::POS_W-1:0]   position;

    modport source (output valid, output action, output value, output position, input ready);
    modport sink   (input valid, input action, input value, input position, output ready);
endinterface

interface ole_out_if;
    logic                        valid;
    logic                        ready;
    logic [ole_pkg::STAT_W-1:0]  status;
    ole_pkg::t_data              read_value;
    logic [ole_pkg::COUNT_W-1:0] count;

    modport source (output valid, output status, output read_value, output count, input ready);
    modport sink   (input valid, input status, input read_value, input count, output ready);
endinterface

>>> rtl/core/ole_cell.sv
// One storage cell of the ordered list: an entry, its compare flags and neighbor moves.
module ole_cell (
    input  logic                 i_clk,
    input  ole_pkg::t_cell_ctl   i_ctl,
    input  ole_pkg::t_data       i_value,
    input  ole_pkg::t_data       i_prev,
    input  ole_pkg::t_data       i_next,
    output ole_pkg::t_data       o_entry,
    output ole_pkg::t_cell_flags o_flags
);
    import ole_pkg::*;

    t_data       r_entry;
    t_cell_flags r_flags;

    always_ff @(posedge i_clk) begin
        if (i_ctl.eval) begin
            r_flags.stop_ins <= !(i_ctl.live && (r_entry < i_value));
            r_flags.hit_del  <= i_ctl.live && (r_entry == i_value);
        end
        if (i_ctl.take_val) begin
            r_entry <= i_value;
        end else if (i_ctl.take_prev) begin
            r_entry <= i_prev;
        end else if (i_ctl.take_next) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
    assign o_flags = r_flags;

endmodule

>>> rtl/core/ordered_list_engine_unit.sv
// Ordered list engine: a row of entry cells with a compare-then-shift sequencer.
// Each word passes from acceptance to its result through the sequencer states: idle,
// in which it is accepted; eval, in which every cell compares its entry with the
// operand and registers the outcome; and apply, in which the row shifts by one place
// where the operation calls for it and the result word is loaded into the output register.
// A waiting result does not block the next input word; a second result waits in apply until the first is taken.
// Every operation (append, sorted insert, delete first match, clear, indexed
// read) gives one result word with status, read value and the count after it.
`include "ordered_list_engine_unit_macros.svh"

module ordered_list_engine_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    ole_in_if.sink    i_in,
    ole_out_if.source o_out
);
    import ole_pkg::*;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_used;
    logic [ACT_W-1:0]      r_act;
    t_data                 r_val;
    logic [POS_W-1:0]      r_pos;

    logic                  r_out_valid;
    logic [STAT_W-1:0]     r_status;
    t_data                 r_rd;
    logic [COUNT_W-1:0]    r_count;

    logic                  w_ready, w_eval, w_apply, w_out_free;
    logic                  w_full, w_found, w_range;

    t_cell_ctl             w_ctl   [DEPTH];
    t_cell_flags           w_flag  [DEPTH];
    t_data                 w_entry [DEPTH];
    t_data                 w_prev  [DEPTH];
    t_data                 w_next  [DEPTH];
    logic [DEPTH-1:0]      w_stop_vec, w_hit_vec, w_stop_upto, w_hit_upto, w_stop_after;

    logic [STAT_W-1:0]     n_status;
    t_data                 n_rd;
    logic [CNT_W-1:0]      n_used;

    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_full     = r_used >= CNT_W'(DEPTH);
    assign w_found    = |w_hit_vec;
    assign w_range    = 32'(r_pos) >= 32'(r_used);

    // Sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in.valid) n_state = S_EVAL;
            S_EVAL:  n_state = S_APPLY;
            S_APPLY: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_ready = 1'b0;
        w_eval  = 1'b0;
        w_apply = 1'b0;
        case (r_state)
            S_IDLE:  w_ready = 1'b1;
            S_EVAL:  w_eval  = 1'b1;
            S_APPLY: w_apply = w_out_free;
            default: ;
        endcase
    end

    assign i_in.ready = w_ready;

    // Cell row
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        assign w_stop_vec[gi]  = w_flag[gi].stop_ins;
        assign w_hit_vec[gi]   = w_flag[gi].hit_del;
        assign w_stop_upto[gi] = |w_stop_vec[gi:0];
        assign w_hit_upto[gi]  = |w_hit_vec[gi:0];

        if (gi == 0) begin : g_head
            assign w_prev[gi]       = r_val;
            assign w_stop_after[gi] = 1'b0;
        end else begin : g_body
            assign w_prev[gi]       = w_entry[gi-1];
            assign w_stop_after[gi] = w_stop_upto[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_next[gi] = '0;
        end else begin : g_link
            assign w_next[gi] = w_entry[gi+1];
        end

        always_comb begin
            w_ctl[gi]           = '0;
            w_ctl[gi].live      = CNT_W'(gi) < r_used;
            w_ctl[gi].eval      = w_eval;
            if (w_apply) begin
                case (r_act)
                    ACT_APPEND: begin
                        w_ctl[gi].take_val = !w_full && (CNT_W'(gi) == r_used);
                    end
                    ACT_INSERT: begin
                        w_ctl[gi].take_val  = !w_full && w_stop_upto[gi]
                                              && !w_stop_after[gi];
                        w_ctl[gi].take_prev = !w_full && w_stop_after[gi]
                                              && (CNT_W'(gi) <= r_used);
                    end
                    ACT_DELETE: begin
                        // close the gap behind the first match
                        w_ctl[gi].take_next = w_found && w_hit_upto[gi]
                                              && ((CNT_W + 1)'(gi + 1) < {1'b0, r_used});
                    end
                    default: ;
                endcase
            end
        end

        ole_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[gi]),
            .i_value (r_val),
            .i_prev  (w_prev[gi]),
            .i_next  (w_next[gi]),
            .o_entry (w_entry[gi]),
            .o_flags (w_flag[gi])
        );
    end

    // Result of the current operation
    always_comb begin
        n_status = STAT_OK;
        n_rd     = '0;
        n_used   = r_used;
        case (r_act)
            ACT_APPEND, ACT_INSERT: begin
                if (w_full) n_status = STAT_FULL;
                else        n_used   = r_used + 1'b1;
            end
            ACT_DELETE: begin
                if (r_used == '0)  n_status = STAT_EMPTY;
                else if (!w_found) n_status = STAT_NOT_FOUND;
                else               n_used   = r_used - 1'b1;
            end
            ACT_CLEAR: n_used = '0;
            ACT_READ: begin
                if (w_range) n_status = STAT_RANGE;
                else         n_rd     = w_entry[IDX_W'(r_pos)];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_apply) begin
                r_used      <= n_used;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers: hold the operand and the result word
    always_ff @(posedge i_clk) begin
        if (i_in.valid && w_ready) begin
            r_act <= i_in.action;
            r_val <= i_in.value;
            r_pos <= i_in.position;
        end
        if (w_apply) begin
            r_status <= n_status;
            r_rd     <= n_rd;
            r_count  <= COUNT_W'(n_used);
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.status     = r_status;
    assign o_out.read_value = r_rd;
    assign o_out.count      = r_count;

    `OLE_ASSERT_NOW(a_used_bound, 1'b1, r_used <= CNT_W'(DEPTH), "entry count above depth")
    `OLE_ASSERT_NEXT(a_accept_eval, i_in.valid && i_in.ready, r_state == S_EVAL, "accepted word not evaluated")
    `OLE_ASSERT_NEXT(a_apply_out, w_apply, r_out_valid, "applied word gave no result")
    `OLE_ASSERT_NEXT(a_insert_grow, w_apply && (r_act == ACT_INSERT) && !w_full, r_used == CNT_W'($past(r_used) + 1'b1), "insert did not grow the list")

endmodule

>>> verif/ordered_list_engine_unit_checker.sv
// Scoreboard for the ordered list engine: shadow list, expected result words and compare.
module ordered_list_engine_unit_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ole_in_if    i_in_mon,
    ole_out_if   i_out_mon,
    output int   o_mismatches,
    output int   o_waiting,
    output int   o_checked
);
    import ole_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        t_data              read_value;
        logic [COUNT_W-1:0] count;
    } t_list_result;

    t_data        shadow_entries [DEPTH];
    int           shadow_len = 0;
    t_list_result pending_results [$];
    int           mismatch_total = 0;
    int           waiting_total = 0;
    int           checked_total = 0;

    assign o_mismatches = mismatch_total;
    assign o_waiting    = waiting_total;
    assign o_checked    = checked_total;

    task automatic report_mismatch(input string what);
        mismatch_total++;
        $display("ERROR: %s", what);
    endtask

    // Apply one operation to the shadow list and return the word it must produce.
    function automatic t_list_result apply_list_op(input logic [ACT_W-1:0] act,
                                                   input t_data val,
                                                   input logic [POS_W-1:0] pos);
        t_list_result res;
        int           slot;
        res.status     = STAT_OK;
        res.read_value = '0;
        case (act)
            ACT_APPEND, ACT_INSERT: begin
                if (shadow_len >= DEPTH) begin
                    res.status = STAT_FULL;
                end else if (act == ACT_APPEND) begin
                    shadow_entries[shadow_len] = val;
                    shadow_len++;
                end else begin
                    // land ahead of the first entry not less than the operand
                    slot = 0;
                    while (slot < shadow_len && shadow_entries[slot] < val) slot++;
                    for (int i = shadow_len; i > slot; i--) begin
                        shadow_entries[i] = shadow_entries[i-1];
                    end
                    shadow_entries[slot] = val;
                    shadow_len++;
                end
            end
            ACT_DELETE: begin
                if (shadow_len == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    slot = 0;
                    while (slot < shadow_len && shadow_entries[slot] != val) slot++;
                    if (slot >= shadow_len) begin
                        res.status = STAT_NOT_FOUND;
                    end else begin
                        for (int i = slot; i + 1 < shadow_len; i++) begin
                            shadow_entries[i] = shadow_entries[i+1];
                        end
                        shadow_len--;
                    end
                end
            end
            ACT_CLEAR: begin
                shadow_len = 0;
            end
            ACT_READ: begin
                if (int'(pos) >= shadow_len) begin
                    res.status = STAT_RANGE;
                end else begin
                    res.read_value = shadow_entries[pos];
                end
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(shadow_len);
        return res;
    endfunction

    always @(posedge i_clk) begin : track
        t_list_result want;
        if (!i_rst_n) begin
            shadow_len = 0;
            pending_results.delete();
        end else begin
            // compare the outgoing word first: it always belongs to an older input
            if (i_out_mon.valid && i_out_mon.ready) begin
                checked_total++;
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected word status %0d value %0d count %0d",
                        i_out_mon.status, i_out_mon.read_value, i_out_mon.count));
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_mon.status !== want.status) begin
                        report_mismatch($sformatf("word %0d status got %0d expected %0d",
                            checked_total, i_out_mon.status, want.status));
                    end
                    if (i_out_mon.read_value !== want.read_value) begin
                        report_mismatch($sformatf("word %0d read_value got %0d expected %0d",
                            checked_total, i_out_mon.read_value, want.read_value));
                    end
                    if (i_out_mon.count !== want.count) begin
                        report_mismatch($sformatf("word %0d count got %0d expected %0d",
                            checked_total, i_out_mon.count, want.count));
                    end
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                pending_results.push_back(apply_list_op(i_in_mon.action, i_in_mon.value,
                                                        i_in_mon.position));
            end
        end
        waiting_total = pending_results.size();
    end

endmodule

>>> verif/ordered_list_engine_unit_tb.sv
// Testbench top for the ordered list engine: stimulus, output stalls and verdict.
module ordered_list_engine_unit_tb;
    import ole_pkg::*;

    localparam int RANDOM_WORDS = 1000;
    localparam logic [ACT_W-1:0] ACT_SPARE_FIRST = ACT_READ + 1'b1;
    localparam logic [ACT_W-1:0] ACT_SPARE_LAST  = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   mismatches;
    int   waiting;
    int   checked;
    int   sent_by_act [8] = '{default: 0};

    ole_in_if  in_ch ();
    ole_out_if out_ch ();

    ordered_list_engine_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    ordered_list_engine_unit_checker scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_mismatches (mismatches),
        .o_waiting    (waiting),
        .o_checked    (checked)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Present one word and hold it until the block takes it.
    task automatic offer_word(input logic [ACT_W-1:0] act, input t_data val,
                              input logic [POS_W-1:0] pos);
        in_ch.valid    <= 1'b1;
        in_ch.action   <= act;
        in_ch.value    <= val;
        in_ch.position <= pos;
        sent_by_act[act]++;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic pause_sender(input int cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Mostly a small pool so deletes hit and inserts collide, plus extremes and noise.
    function automatic t_data pick_value();
        t_data v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: v = t_data'($urandom_range(0, 8)) - 4;
            6: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7FFF_FFFF;
                    2:       v = '1;
                    default: v = '0;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [ACT_W-1:0] pick_action(input bit filling);
        int r;
        r = $urandom_range(0, 99);
        if (filling) begin
            if (r < 35)      return ACT_APPEND;
            else if (r < 70) return ACT_INSERT;
            else if (r < 82) return ACT_DELETE;
            else if (r < 96) return ACT_READ;
            else if (r < 97) return ACT_CLEAR;
        end else begin
            if (r < 10)      return ACT_APPEND;
            else if (r < 25) return ACT_INSERT;
            else if (r < 70) return ACT_DELETE;
            else if (r < 93) return ACT_READ;
            else if (r < 96) return ACT_CLEAR;
        end
        return ACT_W'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
    endfunction

    initial begin : stimulus
        int               sent;
        int               burst_len;
        int               gap;
        int               phase_left;
        bit               filling;
        logic [ACT_W-1:0] act;
        i_rst_n        <= 1'b0;
        in_ch.valid    <= 1'b0;
        in_ch.action   <= ACT_APPEND;
        in_ch.value    <= '0;
        in_ch.position <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty-list corner cases
        offer_word(ACT_DELETE, 32'sd7, '0);
        offer_word(ACT_READ, '0, 4'd0);
        offer_word(ACT_CLEAR, '0, '0);
        // extremes, and a duplicate that must land ahead of its twin
        offer_word(ACT_INSERT, 32'sd0, '0);
        offer_word(ACT_INSERT, 32'h7FFF_FFFF, '0);
        offer_word(ACT_INSERT, 32'h8000_0000, '0);
        offer_word(ACT_INSERT, 32'sd0, '0);
        offer_word(ACT_APPEND, -32'sd1, 4'hF);
        offer_word(ACT_READ, '0, 4'd4);
        offer_word(ACT_READ, '0, 4'd5);
        offer_word(ACT_DELETE, 32'sd12345, '0);
        offer_word(ACT_DELETE, 32'sd0, '0);
        offer_word(ACT_SPARE_FIRST, $urandom, 4'hA);
        // fill to the top, then bounce off it
        repeat (12) begin
            offer_word($urandom_range(0, 1) ? ACT_INSERT : ACT_APPEND, pick_value(),
                       POS_W'($urandom_range(0, 15)));
        end
        offer_word(ACT_APPEND, 32'sd99, '0);
        offer_word(ACT_INSERT, -32'sd99, '0);
        offer_word(ACT_READ, '0, 4'd15);
        offer_word(ACT_CLEAR, '0, '0);

        // random bursts, alternating between growing and draining the list
        sent       = 0;
        filling    = 1'b1;
        phase_left = $urandom_range(10, 50);
        while (sent < RANDOM_WORDS) begin
            burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                    : $urandom_range(1, 12);
            repeat (burst_len) begin
                if (phase_left == 0) begin
                    filling    = !filling;
                    phase_left = $urandom_range(10, 50);
                end
                phase_left--;
                act = pick_action(filling);
                offer_word(act, pick_value(), POS_W'($urandom_range(0, 15)));
                if (act <= ACT_READ) sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) pause_sender(gap);
        end
        in_ch.valid <= 1'b0;

        // let the last accepted word reach the scoreboard, then drain
        @(posedge i_clk);
        wait (waiting == 0);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d append, %0d insert, %0d delete, %0d clear, %0d read words",
                 sent_by_act[ACT_APPEND], sent_by_act[ACT_INSERT], sent_by_act[ACT_DELETE],
                 sent_by_act[ACT_CLEAR], sent_by_act[ACT_READ]);
        $display("plus %0d spare-code words; %0d result words compared",
                 sent_by_act[5] + sent_by_act[6] + sent_by_act[7], checked);
        if (mismatches == 0 && waiting == 0) begin
            $display("ordered_list_engine_unit verification clean");
        end else begin
            $display("ordered_list_engine_unit verification failed");
        end
        $finish;
    end

    // Output side: shifting stall modes, plus long hold-offs that back up the input.
    initial begin : receiver
        int mode;
        int mode_left;
        int hold;
        int cycle_no;
        mode      = 0;
        mode_left = 0;
        hold      = 0;
        cycle_no  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            cycle_no++;
            if (hold == 0 && (cycle_no == 300 || $urandom_range(0, 1999) == 0)) begin
                hold = $urandom_range(60, 100);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            if (hold > 0) begin
                hold--;
                out_ch.ready <= 1'b0;
            end else begin
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: out_ch.ready <= (cycle_no % 3 != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        #(12 * 400000);
        $display("ordered_list_engine_unit verification failed");
        $finish;
    end

endmodule
